FILE: src/pmcp_pkg.sv
// shared types, constants and functions for the power module can poller
package pmcp_pkg;

    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 104;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_WORD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_SETPOINT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_SETPOINT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_SETPOINT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_LIMIT       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_READY_LOW_LEVEL  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_READY_HIGH_LEVEL = 3'd6;

    localparam logic [7:0]  WAIT_LIMIT_RESET = 8'd100;
    localparam logic [15:0] READY_LOW_RESET  = 16'd1500;
    localparam logic [15:0] READY_HIGH_RESET = 16'd1800;

    localparam logic [10:0] ID_CTRL_BASE = 11'h600;
    localparam logic [10:0] ID_STAT_BASE = 11'h610;
    localparam logic [10:0] ID_VOLT_OUT  = 11'h612;
    localparam logic [3:0]  GROUP_NONE       = 4'd0;
    localparam logic [3:0]  GROUP_CTRL_FIRST = 4'd1;
    localparam logic [3:0]  GROUP_STAT_FIRST = 4'd5;

    localparam logic [3:0]  FIRST_WRITE = 4'd8;
    localparam logic [3:0]  LAST_ACCESS = 4'd11;
    localparam logic [2:0]  SEND_LEN_NONE  = 3'd0;
    localparam logic [2:0]  SEND_LEN_WRITE = 3'd4;
    localparam logic [15:0] WRITE_TAIL     = 16'h0001;
    localparam logic [7:0]  WAIT_COUNT_MAX = 8'd255;

    typedef enum logic {
        PHASE_SEND,
        PHASE_WAIT
    } phase_t;

    typedef struct packed {
        logic        is_frame;
        logic [10:0] frame_id;
        logic        is_data;
        logic        is_volt;
        logic [3:0]  group;
        logic [15:0] word_first;
        logic [15:0] word_second;
        logic [15:0] word_third;
    } item_t;

    typedef struct packed {
        logic [15:0] command_word;
        logic [15:0] power_setpoint;
        logic [15:0] voltage_setpoint;
        logic [15:0] current_setpoint;
        logic [7:0]  wait_limit;
        logic [15:0] ready_low_level;
        logic [15:0] ready_high_level;
    } cfg_t;

    typedef struct packed {
        logic        send_valid;
        logic [10:0] send_id;
        logic        send_remote;
        logic [2:0]  send_length;
        logic [31:0] send_payload;
        logic [3:0]  received_group;
        logic [15:0] word_first;
        logic [15:0] word_second;
        logic [15:0] word_third;
        logic        capacitor_ready;
    } result_t;

    function automatic logic [10:0] access_id(input logic [3:0] idx);
        logic [10:0] id;
        case (idx)
            4'd0:    id = 11'h600;
            4'd1:    id = 11'h601;
            4'd2:    id = 11'h602;
            4'd3:    id = 11'h603;
            4'd4:    id = 11'h610;
            4'd5:    id = 11'h611;
            4'd6:    id = 11'h612;
            4'd7:    id = 11'h613;
            4'd8:    id = 11'h600;
            4'd9:    id = 11'h601;
            4'd10:   id = 11'h602;
            4'd11:   id = 11'h603;
            default: id = 11'h600;
        endcase
        return id;
    endfunction

endpackage

FILE: src/pmcp_front.sv
// front end: unpacks and classifies incoming ticks and frames
module pmcp_front
    import pmcp_pkg::*;
(
    input  logic                 s_tvalid,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 push_valid,
    output item_t                push_item
);

    logic [10:0] id;
    logic        remote;
    logic [47:0] payload;
    logic [3:0]  group;

    assign id      = s_tdata[10:0];
    assign remote  = s_tdata[11];
    assign payload = s_tdata[59:12];

    always_comb begin
        if (id[10:2] == ID_CTRL_BASE[10:2]) begin
            group = GROUP_CTRL_FIRST + {2'b00, id[1:0]};
        end else if (id[10:2] == ID_STAT_BASE[10:2]) begin
            group = GROUP_STAT_FIRST + {2'b00, id[1:0]};
        end else begin
            group = GROUP_NONE;
        end
    end

    always_comb begin
        push_item.is_frame    = s_tuser;
        push_item.frame_id    = id;
        push_item.is_data     = s_tuser && !remote && (group != GROUP_NONE);
        push_item.is_volt     = s_tuser && !remote && (id == ID_VOLT_OUT);
        push_item.group       = push_item.is_data ? group : GROUP_NONE;
        push_item.word_first  = payload[47:32];
        push_item.word_second = payload[31:16];
        push_item.word_third  = payload[15:0];
    end

    assign push_valid = s_tvalid;

endmodule

FILE: src/pmcp_queue.sv
// short fifo between the front end and the sequencer
module pmcp_queue
    import pmcp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/pmcp_back.sv
// back end: send/wait sequencer, ready flag and output register
module pmcp_back
    import pmcp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  item_t   pop_item,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_result
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  access_index_reg, access_index_next;
    logic [7:0]  wait_count_reg, wait_count_next;
    logic [10:0] pending_id_reg, pending_id_next;
    logic        response_seen_reg, response_seen_next;
    logic        ready_flag_reg, ready_flag_next;
    logic        out_valid_reg;
    result_t     out_reg, out_next;
    logic        step;
    logic        is_tick;
    logic [15:0] setting;
    logic [7:0]  wait_count_upd;

    assign pop_ready = !out_valid_reg || m_tready;
    assign step      = pop_valid && pop_ready;
    assign is_tick   = !pop_item.is_frame;
    assign m_tvalid  = out_valid_reg;
    assign m_result  = out_reg;

    always_comb begin
        case (access_index_reg)
            4'd8:    setting = cfg.command_word;
            4'd9:    setting = cfg.power_setpoint;
            4'd10:   setting = cfg.voltage_setpoint;
            default: setting = cfg.current_setpoint;
        endcase
    end

    always_comb begin
        if (response_seen_reg || wait_count_reg == WAIT_COUNT_MAX) begin
            wait_count_upd = wait_count_reg;
        end else begin
            wait_count_upd = wait_count_reg + 8'd1;
        end
    end

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (step && is_tick) begin
            case (phase_reg)
                PHASE_SEND: phase_next = PHASE_WAIT;
                PHASE_WAIT: begin
                    if (response_seen_reg || wait_count_upd > cfg.wait_limit) begin
                        phase_next = PHASE_SEND;
                    end
                end
                default: phase_next = PHASE_SEND;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        access_index_next  = access_index_reg;
        wait_count_next    = wait_count_reg;
        pending_id_next    = pending_id_reg;
        response_seen_next = response_seen_reg;
        ready_flag_next    = ready_flag_reg;
        out_next           = '0;
        if (is_tick) begin
            if (phase_reg == PHASE_SEND) begin
                wait_count_next     = '0;
                pending_id_next     = access_id(access_index_reg);
                out_next.send_valid = 1'b1;
                out_next.send_id    = access_id(access_index_reg);
                if (access_index_reg >= FIRST_WRITE && access_index_reg <= LAST_ACCESS) begin
                    out_next.send_length  = SEND_LEN_WRITE;
                    out_next.send_payload = {setting, WRITE_TAIL};
                end else begin
                    out_next.send_remote = 1'b1;
                    out_next.send_length = SEND_LEN_NONE;
                end
            end else begin
                wait_count_next = wait_count_upd;
                if (response_seen_reg) begin
                    response_seen_next = 1'b0;
                    access_index_next  = (access_index_reg == LAST_ACCESS) ?
                                         4'd0 : access_index_reg + 4'd1;
                end
            end
        end else begin
            response_seen_next = (pop_item.frame_id == pending_id_reg);
            if (pop_item.is_data) begin
                out_next.received_group = pop_item.group;
                out_next.word_first     = pop_item.word_first;
                out_next.word_second    = pop_item.word_second;
                out_next.word_third     = pop_item.word_third;
            end
            if (pop_item.is_volt) begin
                if (pop_item.word_second < cfg.ready_low_level) begin
                    ready_flag_next = 1'b0;
                end else if (pop_item.word_second > cfg.ready_high_level) begin
                    ready_flag_next = 1'b1;
                end
            end
        end
        out_next.capacitor_ready = ready_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PHASE_SEND;
            access_index_reg  <= '0;
            wait_count_reg    <= '0;
            pending_id_reg    <= '0;
            response_seen_reg <= 1'b0;
            ready_flag_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (step) begin
                phase_reg         <= phase_next;
                access_index_reg  <= access_index_next;
                wait_count_reg    <= wait_count_next;
                pending_id_reg    <= pending_id_next;
                response_seen_reg <= response_seen_next;
                ready_flag_reg    <= ready_flag_next;
                out_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: src/power_module_can_poller.sv
// top level of the power module can poller: config registers and stream ports
//
// Polling master for a supercapacitor power module. Each input transaction is a
// poll tick (tuser 1'b0) or a received frame (tuser 1'b1) and yields exactly one
// result transaction. A tick in the send phase emits the next of twelve accesses
// (eight remote reads, then four writes carrying the setting registers); a tick
// in the wait phase advances on a matched response or resends on timeout. Data
// frames from the module are returned as a group and three big-endian words, and
// the voltage-out frame drives the hysteresis capacitor_ready flag. The block
// takes one transaction per clock while m_tready stays high: classification is
// combinational into a two-entry queue, the sequencer retires one queue entry
// per cycle into the output register unless the output stalls, so a result is
// registered first in the queue and then in the output register, where m_tvalid
// presents it until m_tready takes it. Configuration writes are always accepted
// and should only be issued while the block is idle.
module power_module_can_poller
    import pmcp_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // frame_id[10:0], frame_remote[11], frame_payload[59:12], zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // command[0]
    input  logic                   s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // send_valid[0], send_id[11:1], send_remote[12], send_length[15:13],
    // send_payload[47:16], received_group[51:48], word_first[67:52],
    // word_second[83:68], word_third[99:84], capacitor_ready[100], zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    logic    push_valid;
    item_t   push_item;
    logic    pop_valid, pop_ready;
    item_t   pop_item;
    result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.command_word     <= '0;
            cfg_reg.power_setpoint   <= '0;
            cfg_reg.voltage_setpoint <= '0;
            cfg_reg.current_setpoint <= '0;
            cfg_reg.wait_limit       <= WAIT_LIMIT_RESET;
            cfg_reg.ready_low_level  <= READY_LOW_RESET;
            cfg_reg.ready_high_level <= READY_HIGH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COMMAND_WORD:     cfg_reg.command_word     <= cfg_data;
                CFG_POWER_SETPOINT:   cfg_reg.power_setpoint   <= cfg_data;
                CFG_VOLTAGE_SETPOINT: cfg_reg.voltage_setpoint <= cfg_data;
                CFG_CURRENT_SETPOINT: cfg_reg.current_setpoint <= cfg_data;
                CFG_WAIT_LIMIT:       cfg_reg.wait_limit       <= cfg_data[7:0];
                CFG_READY_LOW_LEVEL:  cfg_reg.ready_low_level  <= cfg_data;
                CFG_READY_HIGH_LEVEL: cfg_reg.ready_high_level <= cfg_data;
                default: ;
            endcase
        end
    end

    pmcp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    pmcp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (s_tready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pmcp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {3'b000,
                      result.capacitor_ready,
                      result.word_third,
                      result.word_second,
                      result.word_first,
                      result.received_group,
                      result.send_payload,
                      result.send_length,
                      result.send_remote,
                      result.send_id,
                      result.send_valid};

endmodule
